>>> rtl/ntp_srb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_srb_pkg: shared types and constants for the NTP server reply builder
// Request descriptor format, verdict codes and fixed reply field values.
// ----------------------------------------------------------------------------
package ntp_srb_pkg;

  localparam int REPLY_LEN   = 48;
  localparam int BYTE_IDX_W  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [BYTE_IDX_W-1:0] LAST_IDX  = BYTE_IDX_W'(REPLY_LEN - 1);
  localparam logic [BYTE_IDX_W-1:0] COUNT_MAX = '1;
  localparam logic [BYTE_IDX_W-1:0] MODE_POS  = 6'd0;
  localparam logic [BYTE_IDX_W-1:0] POLL_POS  = 6'd2;
  localparam logic [BYTE_IDX_W-1:0] ORIG_LO   = 6'd40;
  localparam logic [BYTE_IDX_W-1:0] ORIG_HI   = 6'd47;

  localparam logic signed [7:0] POLL_MIN = 8'sd4;
  localparam logic signed [7:0] POLL_MAX = 8'sd17;

  localparam logic [2:0]  MODE_CLIENT = 3'd3;
  localparam logic [2:0]  MODE_SERVER = 3'd4;
  localparam logic [2:0]  VERSION_MIN = 3'd1;
  localparam logic [2:0]  VERSION_MAX = 3'd4;
  localparam logic [31:0] ID_INIT     = 32'h494E_4954;  // "INIT"
  localparam logic [31:0] ID_FALLBACK = 32'h5757_5600;

  localparam logic [1:0] LEAP_NONE   = 2'd0;
  localparam logic [1:0] LEAP_INSERT = 2'd1;
  localparam logic [1:0] LEAP_ALARM  = 2'd3;

  // config register indexes
  localparam logic [1:0] CFG_ANSWER_UNSYNCED = 2'd0;
  localparam logic [1:0] CFG_HONOUR_LEAP     = 2'd1;
  localparam logic [1:0] CFG_PRECISION       = 2'd2;
  localparam logic [5:0] PRECISION_RESET     = 6'h2C;  // -20

  typedef enum logic [2:0] {
    VERDICT_REPLY     = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_NOT_MODE3 = 3'd2,
    VERDICT_BAD_VER   = 3'd3,
    VERDICT_REFUSED   = 3'd4
  } verdict_e;

  // one judged request, everything the back end needs to stream the reply
  typedef struct packed {
    verdict_e    verdict;
    logic [1:0]  leap;
    logic [2:0]  version;
    logic        stratum;
    logic [7:0]  poll;
    logic [7:0]  precision;
    logic [31:0] dispersion;
    logic [31:0] refid;
    logic [63:0] ref_time;
    logic [63:0] origin;
    logic [63:0] receive;
    logic [63:0] transmit;
  } desc_t;

endpackage

>>> rtl/ntp_server_reply_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_server_reply_builder: NTPv4 server-mode reply generator
// Parses a client request byte stream and streams back the mode-4 reply.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request byte per transfer
//   together with the clock/source status; last_byte_i closes the request.
//   Output channel (out_valid_o/out_ready_i) gives 48 reply bytes per good
//   request, reply_last_o on the final one, or one zero byte carrying the
//   drop verdict. Config writes (cfg_we_i) are registered; the user must make
//   them only while no request is in flight, which the block does not enforce.
//   Throughput: one byte per cycle on both sides when not stalled. The input
//   side stalls only when the two-entry descriptor queue is full, i.e. one
//   judged request still waits behind the reply being streamed.
//   With the queue empty, the transfer of the last request byte writes the
//   judged descriptor into the queue; from there the streamer loads the first
//   result byte into the output register, from where it can transfer.
//   Reset clears the parse state, queue and output register; config returns
//   to answer_unsynced 0, honour_leap 1, precision -20.
//   A receiver stall holds the output register; parsing continues until the
//   queue fills.
// ----------------------------------------------------------------------------
module ntp_server_reply_builder import ntp_srb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [63:0] clock_time_i,
  input  logic        source_valid_i,
  input  logic        synchronised_i,
  input  logic        leap_warning_i,
  input  logic [31:0] root_dispersion_i,
  input  logic [31:0] source_id_i,
  input  logic [63:0] reference_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o,
  output logic [2:0]  verdict_o
);

  logic  push, push_ready, head_valid, pop;
  desc_t push_desc, head_desc;

  ntp_srb_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .clock_time_i      (clock_time_i),
    .source_valid_i    (source_valid_i),
    .synchronised_i    (synchronised_i),
    .leap_warning_i    (leap_warning_i),
    .root_dispersion_i (root_dispersion_i),
    .source_id_i       (source_id_i),
    .reference_time_i  (reference_time_i),
    .push_o            (push),
    .push_desc_o       (push_desc),
    .push_ready_i      (push_ready)
  );

  ntp_srb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc),
    .pop_i        (pop)
  );

  ntp_srb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reply_byte_o (reply_byte_o),
    .reply_last_o (reply_last_o),
    .verdict_o    (verdict_o)
  );

endmodule

>>> rtl/ntp_srb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_srb_front: request parser and judge
// Collects the request fields byte by byte, holds the config registers and
// on the last byte pushes a judged descriptor into the queue.
// ----------------------------------------------------------------------------
module ntp_srb_front import ntp_srb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [63:0] clock_time_i,
  input  logic        source_valid_i,
  input  logic        synchronised_i,
  input  logic        leap_warning_i,
  input  logic [31:0] root_dispersion_i,
  input  logic [31:0] source_id_i,
  input  logic [63:0] reference_time_i,
  output logic        push_o,
  output desc_t       push_desc_o,
  input  logic        push_ready_i
);

  logic                  answer_unsynced_q;
  logic                  honour_leap_q;
  logic [5:0]            precision_q;
  logic [BYTE_IDX_W-1:0] count_q, count_d, count_inc;
  logic [7:0]            mode_q, mode_d;
  logic [7:0]            poll_q, poll_d;
  logic [63:0]           origin_q, origin_d;
  logic [63:0]           receive_q, receive_d;
  logic                  accept;
  logic [2:0]            version;
  verdict_e              verdict;
  logic signed [7:0]     poll_s;
  logic [7:0]            poll_clamped;
  logic [1:0]            leap;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_unsynced_q <= 1'b0;
      honour_leap_q     <= 1'b1;
      precision_q       <= PRECISION_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ANSWER_UNSYNCED: answer_unsynced_q <= cfg_data_i[0];
        CFG_HONOUR_LEAP:     honour_leap_q     <= cfg_data_i[0];
        CFG_PRECISION:       precision_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
    mode_d    = (count_q == MODE_POS) ? data_byte_i : mode_q;
    receive_d = (count_q == MODE_POS) ? clock_time_i : receive_q;
    poll_d    = (count_q == POLL_POS) ? data_byte_i : poll_q;
    origin_d  = (count_q >= ORIG_LO && count_q <= ORIG_HI) ?
                {origin_q[55:0], data_byte_i} : origin_q;
    count_d   = last_byte_i ? '0 : count_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      mode_q    <= '0;
      poll_q    <= '0;
      origin_q  <= '0;
      receive_q <= '0;
    end else if (accept) begin
      count_q   <= count_d;
      mode_q    <= mode_d;
      poll_q    <= poll_d;
      origin_q  <= origin_d;
      receive_q <= receive_d;
    end
  end

  // judge: length, mode, version, then sync, in that priority
  always_comb begin
    version = mode_d[5:3];
    if (count_inc < LAST_IDX + 1'b1) begin
      verdict = VERDICT_SHORT;
    end else if (mode_d[2:0] != MODE_CLIENT) begin
      verdict = VERDICT_NOT_MODE3;
    end else if (version < VERSION_MIN || version > VERSION_MAX) begin
      verdict = VERDICT_BAD_VER;
    end else if (!synchronised_i && !answer_unsynced_q) begin
      verdict = VERDICT_REFUSED;
    end else begin
      verdict = VERDICT_REPLY;
    end

    if (!synchronised_i) begin
      leap = LEAP_ALARM;
    end else if (leap_warning_i && honour_leap_q) begin
      leap = LEAP_INSERT;
    end else begin
      leap = LEAP_NONE;
    end

    poll_s = signed'(poll_d);
    if (poll_s < POLL_MIN) begin
      poll_clamped = POLL_MIN;
    end else if (poll_s > POLL_MAX) begin
      poll_clamped = POLL_MAX;
    end else begin
      poll_clamped = poll_d;
    end
  end

  assign push_o = accept && last_byte_i;

  always_comb begin
    push_desc_o            = '0;
    push_desc_o.verdict    = verdict;
    push_desc_o.leap       = leap;
    push_desc_o.version    = version;
    push_desc_o.stratum    = synchronised_i;
    push_desc_o.poll       = poll_clamped;
    push_desc_o.precision  = {{2{precision_q[5]}}, precision_q};
    push_desc_o.dispersion = root_dispersion_i;
    if (!source_valid_i) begin
      push_desc_o.refid = ID_INIT;
    end else if (source_id_i == '0) begin
      push_desc_o.refid = ID_FALLBACK;
    end else begin
      push_desc_o.refid = source_id_i;
    end
    push_desc_o.ref_time   = source_valid_i ? reference_time_i : '0;
    push_desc_o.origin     = origin_d;
    push_desc_o.receive    = receive_d;
    push_desc_o.transmit   = clock_time_i;
  end

endmodule

>>> rtl/ntp_srb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_srb_queue: descriptor queue between parser and reply streamer
// Small register queue; lets each side stall independently.
// ----------------------------------------------------------------------------
module ntp_srb_queue import ntp_srb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  push_ready_o,
  output logic  head_valid_o,
  output desc_t head_desc_o,
  input  logic  pop_i
);

  desc_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_desc_o  = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ntp_srb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_srb_back: reply streamer
// Walks the head descriptor one byte per transfer into an output register;
// a drop verdict gives a single zero byte.
// ----------------------------------------------------------------------------
module ntp_srb_back import ntp_srb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  desc_t      head_desc_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] reply_byte_o,
  output logic       reply_last_o,
  output logic [2:0] verdict_o
);

  logic [0:REPLY_LEN-1][7:0] reply;
  logic [BYTE_IDX_W-1:0]     idx_q;
  logic                      out_valid_q;
  logic [7:0]                byte_q;
  logic                      last_q;
  verdict_e                  verdict_q;
  logic                      load, drop, at_end;

  // reply image, byte 0 leftmost
  assign reply = {head_desc_i.leap, head_desc_i.version, MODE_SERVER,
                  7'd0, head_desc_i.stratum,
                  head_desc_i.poll,
                  head_desc_i.precision,
                  32'd0,
                  head_desc_i.dispersion,
                  head_desc_i.refid,
                  head_desc_i.ref_time,
                  head_desc_i.origin,
                  head_desc_i.receive,
                  head_desc_i.transmit};

  assign load   = head_valid_i && (!out_valid_q || out_ready_i);
  assign drop   = head_desc_i.verdict != VERDICT_REPLY;
  assign at_end = drop || (idx_q == LAST_IDX);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= at_end ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= drop ? 8'd0 : reply[idx_q];
      last_q    <= at_end;
      verdict_q <= head_desc_i.verdict;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_byte_o = byte_q;
  assign reply_last_o = last_q;
  assign verdict_o    = verdict_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX)
    else $error("byte index past reply end");

  a_drop_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q != VERDICT_REPLY |-> last_q && byte_q == 8'd0)
    else $error("drop result not a single zero byte");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !at_end |=> idx_q == $past(idx_q) + 1'b1)
    else $error("byte index skipped");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(idx_q))
    else $error("stream advanced under stall");

endmodule

>>> tb/sv/ntp_server_reply_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_server_reply_builder_tb: self-checking bench for the NTP reply builder
// Streams request bytes under random flow control on both channels, predicts
// every reply or drop beat in the bench and checks each output transfer in
// order against it, over several register settings.
// ----------------------------------------------------------------------------
module ntp_server_reply_builder_tb;
  import ntp_srb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 300;

  // one request byte with the status sampled alongside it
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [63:0] now;
    logic        src_valid;
    logic        sync;
    logic        leapw;
    logic [31:0] disp;
    logic [31:0] sid;
    logic [63:0] reft;
  } req_byte_t;

  // one whole request; typed rows carry their drop verdict directly
  typedef struct packed {
    logic [6:0]  len;
    logic [7:0]  b0;
    logic [7:0]  poll;
    logic        sync;
    logic        src_valid;
    logic        leapw;
    logic [31:0] disp;
    logic [31:0] sid;
    logic [63:0] reft;
    logic [63:0] t_rx;
    logic [63:0] t_tx;
    logic        typed;
    verdict_e    vexp;
  } req_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    verdict_e   verdict;
  } reply_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [5:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic [63:0] clock_time_i;
  logic        source_valid_i;
  logic        synchronised_i;
  logic        leap_warning_i;
  logic [31:0] root_dispersion_i;
  logic [31:0] source_id_i;
  logic [63:0] reference_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  reply_byte_o;
  logic        reply_last_o;
  logic [2:0]  verdict_o;

  ntp_server_reply_builder DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .clock_time_i      (clock_time_i),
    .source_valid_i    (source_valid_i),
    .synchronised_i    (synchronised_i),
    .leap_warning_i    (leap_warning_i),
    .root_dispersion_i (root_dispersion_i),
    .source_id_i       (source_id_i),
    .reference_time_i  (reference_time_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .reply_byte_o      (reply_byte_o),
    .reply_last_o      (reply_last_o),
    .verdict_o         (verdict_o)
  );

  // bench copy of the parser state and registers
  logic [5:0]  rx_count;
  logic [7:0]  mode_q;
  logic [7:0]  poll_q;
  logic [63:0] orig_q;
  logic [63:0] rx_stamp;
  logic        cfg_answer_unsync;
  logic        cfg_leap_en;
  logic [5:0]  cfg_prec;

  reply_beat_t expected_beats[$];
  reply_beat_t head_beat;

  int tx_idle_pct = 13;
  int rx_idle_pct = 86;
  bit hold_go = 1'b0;
  int hold_left = 0;

  int cycles = 0;
  int fault_count = 0;
  int beats_seen = 0;
  int bytes_sent = 0;
  int requests_sent = 0;
  int replies_seen = 0;
  int drops_seen[5] = '{0, 0, 0, 0, 0};

  req_row_t dir_tbl [8] = '{
    // straight after reset: a lone last byte is too short
    '{7'd1, 8'h23, 8'h00, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0,
      64'h0, 64'h0, 1'b1, VERDICT_SHORT},
    '{7'd47, 8'h23, 8'h06, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0,
      64'h0, 64'h0, 1'b1, VERDICT_SHORT},
    // server mode in the request
    '{7'd48, 8'h24, 8'h06, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0,
      64'h0, 64'h0, 1'b1, VERDICT_NOT_MODE3},
    // version 0
    '{7'd48, 8'h03, 8'h06, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0,
      64'h0, 64'h0, 1'b1, VERDICT_BAD_VER},
    // unsynced with answering disabled
    '{7'd48, 8'h23, 8'h06, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 64'h0,
      64'h0, 64'h0, 1'b1, VERDICT_REFUSED},
    // v1, most negative poll, source never valid, leap pending
    '{7'd48, 8'h0B, 8'h80, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h4750_5300,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, VERDICT_REPLY},
    // long request past saturation, largest poll, zero source id
    '{7'd64, 8'hE3, 8'h7F, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0,
      64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, VERDICT_REPLY},
    // last row runs with answering on and leap warnings ignored
    '{7'd48, 8'h23, 8'h11, 1'b0, 1'b1, 1'b1, 32'h0000_0042, 32'h5054_5000,
      64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000, 64'h0000_0001_8000_0000,
      1'b0, VERDICT_REPLY}
  };

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // advance the parser copy by one byte; on the last byte queue its beats
  function automatic void predict_byte(input req_byte_t it);
    logic [6:0]         total;
    logic [2:0]         ver;
    verdict_e           v;
    logic [1:0]         leap;
    logic signed [7:0]  pl;
    logic [31:0]        id;
    logic [383:0]       img;
    reply_beat_t        beat;
    int                 i;
    if (rx_count == 6'd0) begin
      rx_stamp = it.now;
      mode_q   = it.data;
    end
    if (rx_count == POLL_POS) poll_q = it.data;
    if (rx_count >= ORIG_LO && rx_count <= ORIG_HI) orig_q = {orig_q[55:0], it.data};
    if (rx_count != COUNT_MAX) rx_count++;
    if (!it.last) return;

    total    = {1'b0, rx_count};
    rx_count = '0;
    ver      = mode_q[5:3];
    if (total < 7'(REPLY_LEN)) v = VERDICT_SHORT;
    else if (mode_q[2:0] != MODE_CLIENT) v = VERDICT_NOT_MODE3;
    else if (ver < VERSION_MIN || ver > VERSION_MAX) v = VERDICT_BAD_VER;
    else if (!it.sync && !cfg_answer_unsync) v = VERDICT_REFUSED;
    else v = VERDICT_REPLY;

    if (v != VERDICT_REPLY) begin
      beat.data    = 8'h00;
      beat.last    = 1'b1;
      beat.verdict = v;
      expected_beats.insert(expected_beats.size(), beat);
      return;
    end

    if (!it.sync) leap = LEAP_ALARM;
    else if (it.leapw && cfg_leap_en) leap = LEAP_INSERT;
    else leap = LEAP_NONE;
    pl = signed'(poll_q);
    if (pl < POLL_MIN) pl = POLL_MIN;
    if (pl > POLL_MAX) pl = POLL_MAX;
    if (!it.src_valid) id = ID_INIT;
    else if (it.sid == 32'h0) id = ID_FALLBACK;
    else id = it.sid;
    // whole reply as one big-endian image; root delay stays zero
    img = {leap, ver, MODE_SERVER, 7'd0, it.sync, pl, {2{cfg_prec[5]}}, cfg_prec,
           32'h0, it.disp, id, (it.src_valid ? it.reft : 64'h0),
           orig_q, rx_stamp, it.now};
    for (i = 0; i < REPLY_LEN; i++) begin
      beat.data    = img[383 - 8 * i -: 8];
      beat.last    = (i == REPLY_LEN - 1);
      beat.verdict = VERDICT_REPLY;
      expected_beats.insert(expected_beats.size(), beat);
    end
  endfunction

  // entered and left at a falling edge; valid stays up if the next byte follows
  task automatic send_item(input req_byte_t it, input bit typed, input verdict_e vexp);
    reply_beat_t fix_beat;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= it.data;
    last_byte_i       <= it.last;
    clock_time_i      <= it.now;
    source_valid_i    <= it.src_valid;
    synchronised_i    <= it.sync;
    leap_warning_i    <= it.leapw;
    root_dispersion_i <= it.disp;
    source_id_i       <= it.sid;
    reference_time_i  <= it.reft;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(it);
    if (typed && it.last) begin
      void'(expected_beats.pop_back());
      fix_beat.data    = 8'h00;
      fix_beat.last    = 1'b1;
      fix_beat.verdict = vexp;
      expected_beats.insert(expected_beats.size(), fix_beat);
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_request(input req_row_t r);
    req_byte_t it;
    int        i;
    for (i = 0; i < int'(r.len); i++) begin
      it.data      = (i == 0) ? r.b0 : (i == 2) ? r.poll : 8'($urandom);
      it.last      = (i == int'(r.len) - 1);
      it.now       = (i == 0) ? r.t_rx : (it.last ? r.t_tx : rand64());
      it.src_valid = r.src_valid;
      it.sync      = r.sync;
      it.leapw     = r.leapw;
      it.disp      = r.disp;
      it.sid       = r.sid;
      it.reft      = r.reft;
      send_item(it, r.typed, r.vexp);
    end
    requests_sent++;
  endtask

  function automatic req_row_t rand_request(input bit good);
    req_row_t r;
    int       kind;
    kind  = good ? 0 : $urandom_range(99);
    r.b0  = 8'($urandom);
    r.len = 7'($urandom_range(48, 56));
    if (kind < 60) begin
      r.b0[2:0] = MODE_CLIENT;
      r.b0[5:3] = 3'($urandom_range(int'(VERSION_MIN), int'(VERSION_MAX)));
      r.len = ($urandom_range(4) == 0) ? 7'($urandom_range(49, 72)) : 7'(REPLY_LEN);
    end else if (kind < 68) begin
      if (r.b0[2:0] == MODE_CLIENT) r.b0[2:0] = 3'($urandom_range(2, 0));
    end else if (kind < 76) begin
      r.b0[2:0] = MODE_CLIENT;
      r.b0[5:3] = $urandom_range(1) ? 3'd0 : 3'($urandom_range(5, 7));
      r.len     = 7'(REPLY_LEN);
    end else begin
      r.len = 7'($urandom_range(1, 47));
    end
    r.poll      = $urandom_range(1) ? 8'($urandom_range(0, 24)) : 8'($urandom);
    r.sync      = ($urandom_range(3) != 0);
    r.src_valid = ($urandom_range(4) != 0);
    r.leapw     = 1'($urandom);
    r.disp      = $urandom;
    r.sid       = ($urandom_range(4) == 0) ? 32'h0 : $urandom;
    r.reft      = rand64();
    r.t_rx      = rand64();
    r.t_tx      = rand64();
    r.typed     = 1'b0;
    r.vexp      = VERDICT_REPLY;
    return r;
  endfunction

  // drop valid and hold until every predicted beat has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_beats.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic au, input logic hl, input logic [5:0] prec);
    wait_idle();
    repeat (4) @(negedge clk_i);
    write_reg(CFG_ANSWER_UNSYNCED, {5'd0, au});
    write_reg(CFG_HONOUR_LEAP, {5'd0, hl});
    write_reg(CFG_PRECISION, prec);
    cfg_we_i          <= 1'b0;
    cfg_answer_unsync = au;
    cfg_leap_en       = hl;
    cfg_prec          = prec;
  endtask

  task automatic random_burst(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(19) == 0) wait_idle();
      send_request(rand_request(1'b0));
    end
  endtask

  // receiver: random back-pressure, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (reply_last_o) begin
        if (verdict_o == VERDICT_REPLY) replies_seen++;
        else if (verdict_o <= 3'(VERDICT_REFUSED)) drops_seen[verdict_o]++;
      end
      if (expected_beats.size() == 0) begin
        note_fault($sformatf("beat %0d unexpected: byte %02h last %0b verdict %0d",
                             beats_seen, reply_byte_o, reply_last_o, verdict_o));
      end else begin
        head_beat = expected_beats.pop_front();
        if (reply_byte_o !== head_beat.data || reply_last_o !== head_beat.last ||
            verdict_o !== head_beat.verdict)
          note_fault($sformatf({"beat %0d mismatch: expected byte %02h last %0b ",
                                "verdict %0d, got byte %02h last %0b verdict %0d"},
                               beats_seen, head_beat.data, head_beat.last,
                               head_beat.verdict, reply_byte_o, reply_last_o, verdict_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycles, expected_beats.size());
      $display("ntp_server_reply_builder verification failed");
      $finish;
    end
  end

  initial begin
    int k;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CFG_ANSWER_UNSYNCED;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    data_byte_i       = '0;
    last_byte_i       = 1'b0;
    clock_time_i      = '0;
    source_valid_i    = 1'b0;
    synchronised_i    = 1'b0;
    leap_warning_i    = 1'b0;
    root_dispersion_i = '0;
    source_id_i       = '0;
    reference_time_i  = '0;
    out_ready_i       = 1'b0;
    rx_count          = '0;
    mode_q            = '0;
    poll_q            = '0;
    orig_q            = '0;
    rx_stamp          = '0;
    cfg_answer_unsync = 1'b0;
    cfg_leap_en       = 1'b1;
    cfg_prec          = PRECISION_RESET;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, first at reset settings, then answering unsynced
    for (k = 0; k < 7; k++) send_request(dir_tbl[k]);
    set_config(1'b1, 1'b0, 6'h1F);
    send_request(dir_tbl[7]);
    random_burst(30);

    tx_idle_pct = 86;
    rx_idle_pct = 13;
    set_config(1'b0, 1'b1, 6'h20);
    random_burst(30);

    // no idling; receiver stalls long enough for the input side to back up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(1'b1, 1'b1, 6'h00);
    hold_go = 1'b1;
    repeat (2) @(negedge clk_i);
    repeat (6) send_request(dir_tbl[0]);
    random_burst(30);

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (expected_beats.size() != 0)
      note_fault($sformatf("%0d beats never arrived", expected_beats.size()));

    $display("sent %0d bytes in %0d requests; checked %0d beats, %0d replies",
             bytes_sent, requests_sent, beats_seen, replies_seen);
    $display("drops: short %0d, wrong mode %0d, bad version %0d, refused %0d",
             drops_seen[VERDICT_SHORT], drops_seen[VERDICT_NOT_MODE3],
             drops_seen[VERDICT_BAD_VER], drops_seen[VERDICT_REFUSED]);
    if (fault_count == 0) begin
      $display("ntp_server_reply_builder verification clean");
    end else begin
      $display("%0d faults", fault_count);
      $display("ntp_server_reply_builder verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ntp_srb_pkg.sv
rtl/ntp_srb_front.sv
rtl/ntp_srb_queue.sv
rtl/ntp_srb_back.sv
rtl/ntp_server_reply_builder.sv
tb/sv/ntp_server_reply_builder_tb.sv
